// ----- rtl/adjacency_matrix_clique_check_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the adjacency matrix clique check unit
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_CLIQUE_CHECK_UNIT_DEFINES_SVH
`define ADJACENCY_MATRIX_CLIQUE_CHECK_UNIT_DEFINES_SVH

// same-cycle implication
`define AMCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AMCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/amcc_pkg.sv -----
// ----------------------------------------------------------------------------
// amcc_pkg
// Constants, types and helpers of the adjacency matrix clique check unit.
// ----------------------------------------------------------------------------
`default_nettype none

package amcc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_SET      = 16;
  localparam int WEIGHT_BITS  = 16;

  localparam int VTX_W      = $clog2(MAX_VERTICES);
  localparam int MAT_DEPTH  = MAX_VERTICES * MAX_VERTICES;
  localparam int ADDR_W     = $clog2(MAT_DEPTH);
  localparam int SET_IDX_W  = $clog2(MAX_SET);
  localparam int SET_CNT_W  = $clog2(MAX_SET + 1);

  // port field widths
  localparam int CFG_W      = 7;
  localparam int EDGE_W     = 6;
  localparam int QV_W       = 7;
  localparam int IN_WGT_W   = 16;
  localparam int STAT_W     = 2;
  localparam int MISS_W     = 6;

  localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_COMPLETE = 2'd0,
    ST_MISSING  = 2'd1,
    ST_UNKNOWN  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INS2,
    S_CHECK,
    S_FIN
  } state_e;

  typedef struct packed {
    logic                   we;
    logic                   re;
    logic [ADDR_W-1:0]      addr;
    logic [WEIGHT_BITS-1:0] wdata;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] mat_addr(logic [VTX_W-1:0] row,
                                                 logic [VTX_W-1:0] col);
    int lin;
    lin = int'(row) * MAX_VERTICES + int'(col);
    return lin[ADDR_W-1:0];
  endfunction

  // saturate to WEIGHT_BITS signed bits
  function automatic logic [WEIGHT_BITS-1:0] fit_weight(logic signed [IN_WGT_W-1:0] w);
    logic signed [32:0] wx;
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    wx = 33'(w);
    hi = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
    lo = -hi - 33'sd1;
    if (wx > hi) wx = hi;
    if (wx < lo) wx = lo;
    return wx[WEIGHT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/amcc_ram.sv -----
// ----------------------------------------------------------------------------
// amcc_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module amcc_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 16
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/amcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// amcc_ctrl
// Sequencer: matrix clear, edge insert, per-vertex pair checks, run result.
// ----------------------------------------------------------------------------
`default_nettype none

module amcc_ctrl (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic                                   operation_i,
  input  wire logic [amcc_pkg::EDGE_W-1:0]            edge_a_i,
  input  wire logic [amcc_pkg::EDGE_W-1:0]            edge_b_i,
  input  wire logic signed [amcc_pkg::IN_WGT_W-1:0]   edge_weight_i,
  input  wire logic [amcc_pkg::QV_W-1:0]              query_vertex_i,
  input  wire logic                                   query_last_i,
  input  wire logic [amcc_pkg::CFG_W-1:0]             lim_i,
  output amcc_pkg::mem_req_t                          mem_req_o,
  input  wire logic [amcc_pkg::WEIGHT_BITS-1:0]       mem_rdata_i,
  output logic                                        done_o,
  output logic [amcc_pkg::STAT_W-1:0]                 status_o,
  output logic [amcc_pkg::MISS_W-1:0]                 missing_first_o,
  output logic [amcc_pkg::MISS_W-1:0]                 missing_second_o
);

  amcc_pkg::state_e state_q, state_d;

  logic [amcc_pkg::ADDR_W-1:0]      clr_q;
  logic [amcc_pkg::SET_CNT_W-1:0]   p_q;
  logic                             rd_valid_q;
  logic [amcc_pkg::SET_IDX_W-1:0]   rd_pos_q;
  logic [amcc_pkg::VTX_W-1:0]       rd_u_q;
  logic [amcc_pkg::SET_CNT_W-1:0]   set_count_q;
  amcc_pkg::status_e                run_status_q;
  logic [amcc_pkg::VTX_W-1:0]       miss_a_q;
  logic [amcc_pkg::VTX_W-1:0]       miss_b_q;
  logic [amcc_pkg::SET_IDX_W-1:0]   miss_pos_q;
  logic                             done_q;

  logic [amcc_pkg::VTX_W-1:0]       set_buf_q [amcc_pkg::MAX_SET];
  logic [amcc_pkg::VTX_W-1:0]       a_q;
  logic [amcc_pkg::VTX_W-1:0]       b_q;
  logic [amcc_pkg::WEIGHT_BITS-1:0] w_q;
  logic [amcc_pkg::VTX_W-1:0]       v_q;
  logic                             last_q;
  logic [amcc_pkg::STAT_W-1:0]      status_q;
  logic [amcc_pkg::VTX_W-1:0]       res_a_q;
  logic [amcc_pkg::VTX_W-1:0]       res_b_q;

  logic accept;
  logic is_insert;
  logic ins_ok;
  logic v_known;
  logic run_unknown;
  logic issue;
  logic miss_hit;
  logic chk_done;
  logic [amcc_pkg::VTX_W-1:0] a_in;
  logic [amcc_pkg::VTX_W-1:0] b_in;
  logic [amcc_pkg::VTX_W-1:0] u_rd;

  assign accept      = start && !busy;
  assign is_insert   = (operation_i == amcc_pkg::OP_INSERT);
  assign a_in        = amcc_pkg::VTX_W'(edge_a_i);
  assign b_in        = amcc_pkg::VTX_W'(edge_b_i);
  assign ins_ok      = (amcc_pkg::CFG_W'(edge_a_i) < lim_i) &&
                       (amcc_pkg::CFG_W'(edge_b_i) < lim_i);
  assign v_known     = (query_vertex_i < lim_i);
  assign run_unknown = (run_status_q == amcc_pkg::ST_UNKNOWN);
  assign u_rd        = set_buf_q[p_q[amcc_pkg::SET_IDX_W-1:0]];
  assign issue       = (state_q == amcc_pkg::S_CHECK) && (p_q < set_count_q);
  assign miss_hit    = rd_valid_q && mem_rdata_i[amcc_pkg::WEIGHT_BITS-1];
  assign chk_done    = miss_hit || (!rd_valid_q && (p_q >= set_count_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      amcc_pkg::S_CLEAR: begin
        if (clr_q == amcc_pkg::ADDR_W'(amcc_pkg::MAT_DEPTH - 1)) state_d = amcc_pkg::S_IDLE;
      end
      amcc_pkg::S_IDLE: begin
        if (accept) begin
          if (is_insert) begin
            if (ins_ok) state_d = amcc_pkg::S_INS2;
          end else if (run_unknown || !v_known) begin
            state_d = amcc_pkg::S_FIN;
          end else begin
            state_d = amcc_pkg::S_CHECK;
          end
        end
      end
      amcc_pkg::S_INS2:  state_d = amcc_pkg::S_IDLE;
      amcc_pkg::S_CHECK: begin
        if (chk_done) state_d = amcc_pkg::S_FIN;
      end
      amcc_pkg::S_FIN:   state_d = amcc_pkg::S_IDLE;
      default:           state_d = amcc_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    mem_req_o = '0;
    busy      = 1'b1;
    case (state_q)
      amcc_pkg::S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = clr_q;
        mem_req_o.wdata = amcc_pkg::NO_EDGE;
      end
      amcc_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start && is_insert && ins_ok) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = amcc_pkg::mat_addr(a_in, b_in);
          mem_req_o.wdata = amcc_pkg::fit_weight(edge_weight_i);
        end
      end
      amcc_pkg::S_INS2: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = amcc_pkg::mat_addr(b_q, a_q);
        mem_req_o.wdata = w_q;
      end
      amcc_pkg::S_CHECK: begin
        mem_req_o.re   = issue;
        mem_req_o.addr = amcc_pkg::mat_addr(u_rd, v_q);
      end
      amcc_pkg::S_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= amcc_pkg::S_CLEAR;
      clr_q        <= '0;
      p_q          <= '0;
      rd_valid_q   <= 1'b0;
      set_count_q  <= '0;
      run_status_q <= amcc_pkg::ST_COMPLETE;
      miss_a_q     <= '0;
      miss_b_q     <= '0;
      miss_pos_q   <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == amcc_pkg::S_FIN) && last_q;
      case (state_q)
        amcc_pkg::S_CLEAR: clr_q <= clr_q + 1'b1;
        amcc_pkg::S_IDLE: begin
          p_q        <= '0;
          rd_valid_q <= 1'b0;
          if (accept && !is_insert && !run_unknown && !v_known) begin
            run_status_q <= amcc_pkg::ST_UNKNOWN;
          end
        end
        amcc_pkg::S_CHECK: begin
          p_q        <= p_q + amcc_pkg::SET_CNT_W'(issue);
          rd_valid_q <= issue;
          if (miss_hit && (run_status_q == amcc_pkg::ST_COMPLETE || rd_pos_q < miss_pos_q)) begin
            run_status_q <= amcc_pkg::ST_MISSING;
            miss_a_q     <= rd_u_q;
            miss_b_q     <= v_q;
            miss_pos_q   <= rd_pos_q;
          end
          if (chk_done && set_count_q < amcc_pkg::SET_CNT_W'(amcc_pkg::MAX_SET)) begin
            set_count_q <= set_count_q + 1'b1;
          end
        end
        amcc_pkg::S_FIN: begin
          if (last_q) begin
            set_count_q  <= '0;
            run_status_q <= amcc_pkg::ST_COMPLETE;
            miss_a_q     <= '0;
            miss_b_q     <= '0;
            miss_pos_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q    <= a_in;
      b_q    <= b_in;
      w_q    <= amcc_pkg::fit_weight(edge_weight_i);
      v_q    <= amcc_pkg::VTX_W'(query_vertex_i);
      last_q <= query_last_i;
    end
    if (issue) begin
      rd_pos_q <= p_q[amcc_pkg::SET_IDX_W-1:0];
      rd_u_q   <= u_rd;
    end
    if (state_q == amcc_pkg::S_CHECK && chk_done &&
        set_count_q < amcc_pkg::SET_CNT_W'(amcc_pkg::MAX_SET)) begin
      set_buf_q[set_count_q[amcc_pkg::SET_IDX_W-1:0]] <= v_q;
    end
    if (state_q == amcc_pkg::S_FIN) begin
      status_q <= run_status_q;
      res_a_q  <= (run_status_q == amcc_pkg::ST_MISSING) ? miss_a_q : '0;
      res_b_q  <= (run_status_q == amcc_pkg::ST_MISSING) ? miss_b_q : '0;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign missing_first_o  = amcc_pkg::MISS_W'(res_a_q);
  assign missing_second_o = amcc_pkg::MISS_W'(res_b_q);

endmodule

`default_nettype wire

// ----- rtl/adjacency_matrix_clique_check_unit.sv -----
// ----------------------------------------------------------------------------
// adjacency_matrix_clique_check_unit
// Weighted adjacency matrix with streaming clique test of a vertex run.
// ----------------------------------------------------------------------------
// Command channel: an item is taken on a clock edge with start high and busy
// low. operation_i selects insert (edge_a_i, edge_b_i, edge_weight_i) or
// query (query_vertex_i, query_last_i).
// Insert: two matrix writes if both endpoints are known; busy during the second.
// Query: the new vertex is checked against the n stored run members with one
// matrix read per cycle from the single-port matrix RAM; an unknown vertex or
// a run already marked unknown skips the reads, and a missing edge ends them
// early. The next item waits for busy low.
// On a query with query_last_i set, done_o pulses for one cycle, the first
// cycle with busy low again, carrying status_o, missing_first_o and
// missing_second_o. The receiver cannot stall; results show for that cycle.
// Config: vertex_count_i is written when vertex_count_we_i is high.
// Reset: the matrix RAM is swept to "no edge", one entry per cycle, over all
// MAX_VERTICES * MAX_VERTICES = 4096 entries, with busy high meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module adjacency_matrix_clique_check_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 operation_i,
  input  wire logic [amcc_pkg::EDGE_W-1:0]          edge_a_i,
  input  wire logic [amcc_pkg::EDGE_W-1:0]          edge_b_i,
  input  wire logic signed [amcc_pkg::IN_WGT_W-1:0] edge_weight_i,
  input  wire logic [amcc_pkg::QV_W-1:0]            query_vertex_i,
  input  wire logic                                 query_last_i,
  input  wire logic                                 vertex_count_we_i,
  input  wire logic [amcc_pkg::CFG_W-1:0]           vertex_count_i,
  output logic                                      done_o,
  output logic [amcc_pkg::STAT_W-1:0]               status_o,
  output logic [amcc_pkg::MISS_W-1:0]               missing_first_o,
  output logic [amcc_pkg::MISS_W-1:0]               missing_second_o
);

  logic [amcc_pkg::CFG_W-1:0]       vertex_count_q;
  logic [amcc_pkg::CFG_W-1:0]       lim;
  amcc_pkg::mem_req_t               mem_req;
  logic [amcc_pkg::WEIGHT_BITS-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= amcc_pkg::CFG_W'(64);
    end else if (vertex_count_we_i) begin
      vertex_count_q <= vertex_count_i;
    end
  end

  // indices known below min(vertex_count, MAX_VERTICES)
  assign lim = (int'(vertex_count_q) > amcc_pkg::MAX_VERTICES) ?
               amcc_pkg::CFG_W'(amcc_pkg::MAX_VERTICES) : vertex_count_q;

  amcc_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .edge_a_i         (edge_a_i),
    .edge_b_i         (edge_b_i),
    .edge_weight_i    (edge_weight_i),
    .query_vertex_i   (query_vertex_i),
    .query_last_i     (query_last_i),
    .lim_i            (lim),
    .mem_req_o        (mem_req),
    .mem_rdata_i      (mem_rdata),
    .done_o           (done_o),
    .status_o         (status_o),
    .missing_first_o  (missing_first_o),
    .missing_second_o (missing_second_o)
  );

  amcc_ram #(
    .DEPTH  (amcc_pkg::MAT_DEPTH),
    .ADDR_W (amcc_pkg::ADDR_W),
    .DATA_W (amcc_pkg::WEIGHT_BITS)
  ) u_matrix (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/amcc_checker.sv -----
// ----------------------------------------------------------------------------
// amcc_checker
// Port-level checks of the clique check unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adjacency_matrix_clique_check_unit_defines.svh"

module amcc_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             operation_i,
  input wire logic                             query_last_i,
  input wire logic                             done_o,
  input wire logic [amcc_pkg::STAT_W-1:0]      status_o,
  input wire logic [amcc_pkg::MISS_W-1:0]      missing_first_o,
  input wire logic [amcc_pkg::MISS_W-1:0]      missing_second_o
);

  `AMCC_ASSERT_SAME(a_pair_zero, done_o && status_o != amcc_pkg::ST_MISSING, missing_first_o == '0 && missing_second_o == '0, "pair not zero without missing edge")
  `AMCC_ASSERT_NEXT(a_single_beat, done_o, !done_o, "result strobe longer than one beat")
  `AMCC_ASSERT_NEXT(a_no_spurious, start && !busy && (operation_i == amcc_pkg::OP_INSERT || !query_last_i), !done_o, "result after non-final beat")
  `AMCC_ASSERT_SAME(a_idle_on_done, done_o, !busy, "busy while result shown")

endmodule

bind adjacency_matrix_clique_check_unit amcc_checker u_amcc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .operation_i      (operation_i),
  .query_last_i     (query_last_i),
  .done_o           (done_o),
  .status_o         (status_o),
  .missing_first_o  (missing_first_o),
  .missing_second_o (missing_second_o)
);

`default_nettype wire

// ----- tb/sv/adjacency_matrix_clique_check_unit_tb.sv -----
// ----------------------------------------------------------------------------
// adjacency_matrix_clique_check_unit_tb
// Drives inserts and query runs into the clique check unit. A local copy of
// the weighted matrix and the run state predicts every report. Each done_o
// beat is checked against the oldest prediction. The vertex count is swept
// across its extremes, and the random runs mostly form candidate cliques.
// ----------------------------------------------------------------------------
`default_nettype none

module adjacency_matrix_clique_check_unit_tb;
  import amcc_pkg::*;

  typedef struct {
    status_e           status;
    logic [MISS_W-1:0] first;
    logic [MISS_W-1:0] second;
  } clique_report_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       operation_i = 1'b0;
  logic [EDGE_W-1:0]          edge_a_i = '0;
  logic [EDGE_W-1:0]          edge_b_i = '0;
  logic signed [IN_WGT_W-1:0] edge_weight_i = '0;
  logic [QV_W-1:0]            query_vertex_i = '0;
  logic                       query_last_i = 1'b0;
  logic                       vertex_count_we_i = 1'b0;
  logic [CFG_W-1:0]           vertex_count_i = '0;
  logic                       done_o;
  logic [STAT_W-1:0]          status_o;
  logic [MISS_W-1:0]          missing_first_o;
  logic [MISS_W-1:0]          missing_second_o;

  // predicted graph and run state
  logic signed [WEIGHT_BITS-1:0] edge_weights [MAX_VERTICES][MAX_VERTICES];
  logic [VTX_W-1:0]              run_members [MAX_SET];
  int                            run_len;
  status_e                       run_state;
  logic [VTX_W-1:0]              miss_first;
  logic [VTX_W-1:0]              miss_second;
  int                            miss_pos;
  logic [CFG_W-1:0]              vcount;

  clique_report_t pending_reports [$];
  int             fail_count;
  int             beats_sent;
  int             idle_pct;

  adjacency_matrix_clique_check_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .edge_a_i         (edge_a_i),
    .edge_b_i         (edge_b_i),
    .edge_weight_i    (edge_weight_i),
    .query_vertex_i   (query_vertex_i),
    .query_last_i     (query_last_i),
    .vertex_count_we_i(vertex_count_we_i),
    .vertex_count_i   (vertex_count_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .missing_first_o  (missing_first_o),
    .missing_second_o (missing_second_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin : check_reports
    clique_report_t want;
    if (rst_ni && done_o) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: status %0d first %0d second %0d",
               status_o, missing_first_o, missing_second_o);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
        if (missing_first_o !== want.first) begin
          $error("missing_first: expected %0d, actual %0d", want.first, missing_first_o);
          fail_count++;
        end
        if (missing_second_o !== want.second) begin
          $error("missing_second: expected %0d, actual %0d", want.second, missing_second_o);
          fail_count++;
        end
      end
    end
  end

  function automatic int known_limit();
    return (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
  endfunction

  // input and stored weight widths match, so saturation never changes a value
  task automatic apply_graph_item(input op_e op, input logic [EDGE_W-1:0] a,
                                  input logic [EDGE_W-1:0] b,
                                  input logic signed [IN_WGT_W-1:0] w,
                                  input logic [QV_W-1:0] qv, input logic last);
    int             lim;
    int             p;
    clique_report_t rep;
    lim = known_limit();
    if (op == OP_INSERT) begin
      if (a < lim && b < lim) begin
        edge_weights[a][b] = w;
        edge_weights[b][a] = w;
      end
      return;
    end
    if (run_state != ST_UNKNOWN) begin
      if (qv >= lim) begin
        run_state = ST_UNKNOWN;
      end else begin
        for (p = 0; p < run_len; p++) begin
          if (edge_weights[run_members[p]][qv[VTX_W-1:0]] < 0) begin
            if (run_state == ST_COMPLETE || p < miss_pos) begin
              run_state   = ST_MISSING;
              miss_first  = run_members[p];
              miss_second = qv[VTX_W-1:0];
              miss_pos    = p;
            end
            break;
          end
        end
        if (run_len < MAX_SET) begin
          run_members[run_len] = qv[VTX_W-1:0];
          run_len++;
        end
      end
    end
    if (last) begin
      rep.status = run_state;
      rep.first  = (run_state == ST_MISSING) ? miss_first : '0;
      rep.second = (run_state == ST_MISSING) ? miss_second : '0;
      pending_reports.push_back(rep);
      run_len   = 0;
      run_state = ST_COMPLETE;
      miss_pos  = 0;
    end
  endtask

  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic signed [IN_WGT_W-1:0] pick_weight();
    if ($urandom_range(19) == 0) return IN_WGT_W'($urandom);
    return IN_WGT_W'($urandom_range(0, 32767));
  endfunction

  task automatic send_beat(input op_e op, input logic [EDGE_W-1:0] a,
                           input logic [EDGE_W-1:0] b,
                           input logic signed [IN_WGT_W-1:0] w,
                           input logic [QV_W-1:0] qv, input logic last);
    int gap;
    operation_i    <= op;
    edge_a_i       <= a;
    edge_b_i       <= b;
    edge_weight_i  <= w;
    query_vertex_i <= qv;
    query_last_i   <= last;
    start          <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    apply_graph_item(op, a, b, w, qv, last);
    beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_insert(input logic [EDGE_W-1:0] a, input logic [EDGE_W-1:0] b,
                             input logic signed [IN_WGT_W-1:0] w);
    send_beat(OP_INSERT, a, b, w, QV_W'($urandom), 1'($urandom));
  endtask

  task automatic send_query(input logic [QV_W-1:0] v, input logic last);
    send_beat(OP_QUERY, EDGE_W'($urandom), EDGE_W'($urandom), IN_WGT_W'($urandom), v, last);
  endtask

  // close any open run, then let the last query drain
  task automatic settle();
    if (run_len != 0 || run_state != ST_COMPLETE)
      send_query(QV_W'($urandom_range(0, 127)), 1'b1);
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [CFG_W-1:0] value);
    settle();
    vertex_count_we_i <= 1'b1;
    vertex_count_i    <= value;
    @(posedge clk_i);
    vertex_count_we_i <= 1'b0;
    vcount = value;
  endtask

  task automatic test_field_extremes();
    write_vertex_count(7'd64);
    send_beat(OP_INSERT, 6'd0, 6'd63, 16'sh7FFF, 7'd127, 1'b1);
    send_insert(6'd63, 6'd63, 16'sh8000);
    send_insert(6'd1, 6'd2, 16'sd0);
    send_insert(6'd0, 6'd1, 16'sd1);
    send_insert(6'd0, 6'd2, 16'sd5);
    send_query(7'd0, 1'b0);
    send_query(7'd1, 1'b0);
    send_query(7'd2, 1'b1);
    send_query(7'd0, 1'b0);
    send_query(7'd63, 1'b1);
    send_query(7'd63, 1'b0);
    send_query(7'd63, 1'b1);
    send_query(7'd5, 1'b1);
    send_query(7'd0, 1'b0);
    send_query(7'd100, 1'b0);
    send_query(7'd1, 1'b1);
    send_query(7'd64, 1'b1);
  endtask

  task automatic test_first_missing_order();
    send_insert(6'd10, 6'd11, 16'sd7);
    send_insert(6'd10, 6'd12, 16'sd7);
    send_query(7'd10, 1'b0);
    send_query(7'd11, 1'b0);
    send_query(7'd12, 1'b0);
    send_query(7'd13, 1'b1);
    send_query(7'd0, 1'b0);
    send_query(7'd1, 1'b0);
    send_query(7'd3, 1'b1);
  endtask

  task automatic test_small_vertex_count();
    write_vertex_count(7'd8);
    send_insert(6'd10, 6'd3, 16'sd9);
    send_insert(6'd3, 6'd4, 16'sd9);
    send_query(7'd3, 1'b0);
    send_query(7'd4, 1'b1);
    send_query(7'd3, 1'b0);
    send_query(7'd10, 1'b1);
    send_query(7'd7, 1'b0);
    send_query(7'd8, 1'b1);
    send_query(7'd3, 1'b0);
    send_query(7'd5, 1'b1);
  endtask

  task automatic test_vertex_count_limits();
    write_vertex_count(7'd0);
    send_insert(6'd0, 6'd0, 16'sd1);
    send_query(7'd0, 1'b1);
    write_vertex_count(7'd127);
    send_query(7'd63, 1'b0);
    send_query(7'd64, 1'b1);
    send_query(7'd0, 1'b0);
    send_query(7'd63, 1'b1);
    write_vertex_count(7'd1);
    send_query(7'd0, 1'b0);
    send_query(7'd0, 1'b1);
    write_vertex_count(7'd65);
    send_query(7'd63, 1'b0);
    send_query(7'd1, 1'b1);
  endtask

  task automatic test_interleaved_insert();
    write_vertex_count(7'd64);
    send_query(7'd20, 1'b0);
    send_insert(6'd20, 6'd21, 16'sd3);
    send_query(7'd21, 1'b1);
    send_query(7'd22, 1'b0);
    send_query(7'd23, 1'b1);
    send_insert(6'd22, 6'd23, 16'sd3);
    send_query(7'd22, 1'b0);
    send_query(7'd23, 1'b1);
  endtask

  // 30..45 fill the set; 47 is checked but not stored, so 46 sees no gap to it
  task automatic test_set_overflow();
    int i;
    int j;
    for (i = 30; i <= 46; i++)
      for (j = i + 1; j <= 46; j++)
        send_insert(EDGE_W'(i), EDGE_W'(j), IN_WGT_W'($urandom_range(0, 32767)));
    for (i = 30; i <= 45; i++)
      send_insert(EDGE_W'(i), 6'd47, IN_WGT_W'($urandom_range(0, 32767)));
    for (i = 30; i <= 45; i++)
      send_query(QV_W'(i), 1'b0);
    send_query(7'd47, 1'b0);
    send_query(7'd46, 1'b1);
  endtask

  task automatic send_noise();
    if ($urandom_range(1))
      send_insert(EDGE_W'($urandom), EDGE_W'($urandom), IN_WGT_W'($urandom));
    else
      send_query(QV_W'($urandom_range(0, 127)), $urandom_range(3) == 0);
  endtask

  task automatic send_clique_run();
    logic [QV_W-1:0] members [$];
    int              lim;
    int              len;
    int              i;
    int              j;
    lim = known_limit();
    len = ($urandom_range(19) == 0) ? $urandom_range(MAX_SET - 1, MAX_SET + 4)
                                    : $urandom_range(1, 6);
    for (i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(9) == 0)
        members.push_back(members[i-1]);
      else if (lim == 0 || $urandom_range(15) == 0)
        members.push_back(QV_W'($urandom_range(lim, 127)));
      else
        members.push_back(QV_W'($urandom_range(0, lim - 1)));
    end
    for (i = 0; i < len; i++)
      for (j = i; j < len; j++)
        if (members[i] < lim && members[j] < lim && $urandom_range(9) < 8)
          send_insert(EDGE_W'(members[i]), EDGE_W'(members[j]), pick_weight());
    for (i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0)
        send_insert(EDGE_W'(members[$urandom_range(0, len - 1)]), EDGE_W'(members[i]),
                    pick_weight());
      send_query(members[i], i == len - 1);
    end
  endtask

  task automatic test_random_runs();
    logic [CFG_W-1:0] counts [9];
    int               goal;
    counts = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd2, 7'd16, 7'd40, 7'd65,
               CFG_W'($urandom_range(0, 127))};
    for (int ph = 0; ph < 9; ph++) begin
      write_vertex_count(counts[ph]);
      idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 30 : 70);
      goal = beats_sent + 90;
      while (beats_sent < goal) begin
        if ($urandom_range(4) == 0) send_noise();
        else send_clique_run();
      end
    end
  endtask

  initial begin
    foreach (edge_weights[r, c]) edge_weights[r][c] = '1;
    run_len    = 0;
    run_state  = ST_COMPLETE;
    miss_pos   = 0;
    vcount     = 7'd64;
    fail_count = 0;
    beats_sent = 0;
    idle_pct   = 30;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_first_missing_order();
    test_small_vertex_count();
    test_vertex_count_limits();
    test_interleaved_insert();
    test_set_overflow();
    test_random_runs();
    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
